### hw/rtl/nnsa_pkg.sv
// shared types, constants and helpers of the nearest-neighbour scaler address unit
package nnsa_pkg;

   localparam int MAX_DIMENSION = 4096;
   localparam int FRACTION_BITS = 8;

   localparam int POS_W  = 12;
   localparam int SIZE_W = 13;
   localparam int ORG_W  = 24;
   localparam int EXT_W  = 24;
   localparam int ADDR_W = 24;
   localparam int QUO_W  = 12;
   localparam int NUM_W  = 26;
   localparam int PROD_W = EXT_W + SIZE_W;
   localparam int MUL_W  = QUO_W + SIZE_W;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_INDEX_W = 3;

   localparam int HALF_PIXEL = 1 << (FRACTION_BITS - 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SAMPLING_MODE,
      REG_SRC_WIDTH,
      REG_SRC_HEIGHT,
      REG_ORIGIN_HORIZONTAL,
      REG_ORIGIN_VERTICAL,
      REG_EXTENT_HORIZONTAL,
      REG_EXTENT_VERTICAL
   } csr_index_type;

   typedef struct packed {
      logic [POS_W-1:0] dest_col;
      logic [POS_W-1:0] dest_row;
   } req_type;

   typedef struct packed {
      logic [QUO_W-1:0]  texel_col;
      logic [QUO_W-1:0]  texel_row;
      logic [ADDR_W-1:0] texel_address;
   } rsp_type;

   typedef struct packed {
      logic              sampling_mode;
      logic [SIZE_W-1:0] src_width;
      logic [SIZE_W-1:0] src_height;
      logic [ORG_W-1:0]  origin_horizontal;
      logic [ORG_W-1:0]  origin_vertical;
      logic [EXT_W-1:0]  extent_horizontal;
      logic [EXT_W-1:0]  extent_vertical;
   } csr_type;

   typedef struct packed {
      logic              sampling_mode;
      logic [SIZE_W-1:0] size;
      logic [ORG_W-1:0]  origin;
      logic [EXT_W-1:0]  extent;
   } axis_cfg_type;

   // source sizes above the maximum saturate
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] limit;
      limit = SIZE_W'(MAX_DIMENSION);
      return (size > limit) ? limit : size;
   endfunction

endpackage

### hw/rtl/nnsa_csr.sv
// configuration register file with apb-style access
module nnsa_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [nnsa_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [nnsa_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [nnsa_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output nnsa_pkg::csr_type                 cfg
);
   import nnsa_pkg::*;

   csr_type       cfg_ff;
   csr_type       cfg_in;
   csr_index_type index;
   logic          write_en;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign index      = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_SAMPLING_MODE:     cfg_in.sampling_mode     = csr_pwdata[0];
            REG_SRC_WIDTH:         cfg_in.src_width         = csr_pwdata[SIZE_W-1:0];
            REG_SRC_HEIGHT:        cfg_in.src_height        = csr_pwdata[SIZE_W-1:0];
            REG_ORIGIN_HORIZONTAL: cfg_in.origin_horizontal = csr_pwdata[ORG_W-1:0];
            REG_ORIGIN_VERTICAL:   cfg_in.origin_vertical   = csr_pwdata[ORG_W-1:0];
            REG_EXTENT_HORIZONTAL: cfg_in.extent_horizontal = csr_pwdata[EXT_W-1:0];
            REG_EXTENT_VERTICAL:   cfg_in.extent_vertical   = csr_pwdata[EXT_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sampling_mode     <= 1'b0;
         cfg_ff.src_width         <= SIZE_W'(1);
         cfg_ff.src_height        <= SIZE_W'(1);
         cfg_ff.origin_horizontal <= '0;
         cfg_ff.origin_vertical   <= '0;
         cfg_ff.extent_horizontal <= EXT_W'(1 << FRACTION_BITS);
         cfg_ff.extent_vertical   <= EXT_W'(1 << FRACTION_BITS);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (index)
         REG_SAMPLING_MODE:     csr_prdata = CSR_DATA_W'(cfg_ff.sampling_mode);
         REG_SRC_WIDTH:         csr_prdata = CSR_DATA_W'(cfg_ff.src_width);
         REG_SRC_HEIGHT:        csr_prdata = CSR_DATA_W'(cfg_ff.src_height);
         REG_ORIGIN_HORIZONTAL: csr_prdata = CSR_DATA_W'(cfg_ff.origin_horizontal);
         REG_ORIGIN_VERTICAL:   csr_prdata = CSR_DATA_W'(cfg_ff.origin_vertical);
         REG_EXTENT_HORIZONTAL: csr_prdata = CSR_DATA_W'(cfg_ff.extent_horizontal);
         REG_EXTENT_VERTICAL:   csr_prdata = CSR_DATA_W'(cfg_ff.extent_vertical);
         default:               csr_prdata = '0;
      endcase
   end

   mode_write_lands: assert property (@(posedge clock) disable iff (reset)
      write_en && (index == REG_SAMPLING_MODE)
      |=> cfg_ff.sampling_mode == $past(csr_pwdata[0]))
      else $error("sampling mode write lost");

endmodule

### hw/rtl/nnsa_axis.sv
// one axis: fixed-point offset, scale multiply, pipelined restoring division and clamp
module nnsa_axis (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [nnsa_pkg::POS_W-1:0]   pos,
   input  nnsa_pkg::axis_cfg_type       cfg,
   output logic                         out_valid,
   output logic [nnsa_pkg::QUO_W-1:0]   index
);
   import nnsa_pkg::*;

   // offset stage
   logic [NUM_W-1:0]  pos_fx;
   logic [NUM_W-1:0]  half_fx;
   logic [NUM_W-1:0]  org_fx;
   logic [NUM_W-1:0]  num;
   logic              num_pos;
   logic              zero_s1_in;
   logic              sat_s1_in;
   logic              valid_s1_ff;
   logic              zero_s1_ff;
   logic              sat_s1_ff;
   logic [EXT_W-1:0]  num_s1_ff;

   // multiply stage feeds division stage 0
   logic [PROD_W-1:0] prod_in;

   logic              valid_ff [0:QUO_W];
   logic              zero_ff  [0:QUO_W];
   logic              sat_ff   [0:QUO_W];
   logic [QUO_W-1:0]  quo_ff   [0:QUO_W];
   logic [EXT_W-1:0]  rem_ff   [0:QUO_W-1];
   logic [QUO_W-1:0]  low_ff   [0:QUO_W-1];

   logic [EXT_W:0]    trial    [0:QUO_W-1];
   logic [EXT_W:0]    diff     [0:QUO_W-1];
   logic              ge       [0:QUO_W-1];

   logic [SIZE_W-1:0] size_m1;
   logic [QUO_W-1:0]  index_in;
   logic [QUO_W-1:0]  index_ff;
   logic              out_valid_ff;

   always_comb begin
      pos_fx     = NUM_W'({pos, {FRACTION_BITS{1'b0}}});
      half_fx    = cfg.sampling_mode ? NUM_W'(HALF_PIXEL) : '0;
      org_fx     = {{(NUM_W-ORG_W){cfg.origin[ORG_W-1]}}, cfg.origin};
      num        = pos_fx + half_fx - org_fx;
      num_pos    = !num[NUM_W-1] && (num != '0);
      zero_s1_in = (cfg.size == '0) || (cfg.extent == '0) || !num_pos;
      // num >= extent means the quotient reaches the source size
      sat_s1_in  = !zero_s1_in && (num >= NUM_W'(cfg.extent));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s1_ff <= 1'b0;
         zero_s1_ff  <= 1'b0;
         sat_s1_ff   <= 1'b0;
      end else begin
         valid_s1_ff <= in_valid;
         zero_s1_ff  <= zero_s1_in;
         sat_s1_ff   <= sat_s1_in;
      end
   end

   always_ff @(posedge clock) begin
      num_s1_ff <= num[EXT_W-1:0];
   end

   assign prod_in = PROD_W'(num_s1_ff) * PROD_W'(cfg.size);

   always_comb begin
      for (int i = 0; i < QUO_W; i++) begin
         trial[i] = {rem_ff[i], low_ff[i][QUO_W-1]};
         diff[i]  = trial[i] - {1'b0, cfg.extent};
         ge[i]    = trial[i] >= {1'b0, cfg.extent};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= QUO_W; i++) begin
            valid_ff[i] <= 1'b0;
            zero_ff[i]  <= 1'b0;
            sat_ff[i]   <= 1'b0;
         end
      end else begin
         valid_ff[0] <= valid_s1_ff;
         zero_ff[0]  <= zero_s1_ff;
         sat_ff[0]   <= sat_s1_ff;
         for (int i = 0; i < QUO_W; i++) begin
            valid_ff[i+1] <= valid_ff[i];
            zero_ff[i+1]  <= zero_ff[i];
            sat_ff[i+1]   <= sat_ff[i];
         end
      end
   end

   // the high part of the product is already below the extent, one quotient bit per stage
   always_ff @(posedge clock) begin
      rem_ff[0] <= prod_in[QUO_W+EXT_W-1:QUO_W];
      low_ff[0] <= prod_in[QUO_W-1:0];
      quo_ff[0] <= '0;
      for (int i = 0; i < QUO_W; i++) begin
         quo_ff[i+1] <= {quo_ff[i][QUO_W-2:0], ge[i]};
      end
      for (int i = 0; i < QUO_W - 1; i++) begin
         rem_ff[i+1] <= ge[i] ? diff[i][EXT_W-1:0] : trial[i][EXT_W-1:0];
         low_ff[i+1] <= {low_ff[i][QUO_W-2:0], 1'b0};
      end
   end

   always_comb begin
      size_m1 = cfg.size - SIZE_W'(1);
      priority if (zero_ff[QUO_W]) begin
         index_in = '0;
      end else if (sat_ff[QUO_W]) begin
         index_in = size_m1[QUO_W-1:0];
      end else begin
         index_in = quo_ff[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= valid_ff[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      index_ff <= index_in;
   end

   assign out_valid = out_valid_ff;
   assign index     = index_ff;

   flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({zero_ff[QUO_W], sat_ff[QUO_W]}))
      else $error("zero and saturate both flagged");

endmodule

### hw/rtl/nnsa_addr.sv
// linear source address: row times pitch, then plus column, into the result register
module nnsa_addr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [nnsa_pkg::QUO_W-1:0]    col,
   input  logic [nnsa_pkg::QUO_W-1:0]    row,
   input  logic [nnsa_pkg::SIZE_W-1:0]   pitch,
   output logic                          rsp_valid,
   output nnsa_pkg::rsp_type             rsp_data
);
   import nnsa_pkg::*;

   logic [MUL_W-1:0]  mul_in;
   logic              valid_a_ff;
   logic [ADDR_W-1:0] mul_a_ff;
   logic [QUO_W-1:0]  col_a_ff;
   logic [QUO_W-1:0]  row_a_ff;
   logic [ADDR_W-1:0] addr_in;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   assign mul_in  = MUL_W'(row) * MUL_W'(pitch);
   assign addr_in = mul_a_ff + ADDR_W'(col_a_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_a_ff   <= in_valid;
         rsp_valid_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      mul_a_ff                  <= mul_in[ADDR_W-1:0];
      col_a_ff                  <= col;
      row_a_ff                  <= row;
      rsp_data_ff.texel_col     <= col_a_ff;
      rsp_data_ff.texel_row     <= row_a_ff;
      rsp_data_ff.texel_address <= addr_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   two_stage_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(in_valid, 2))
      else $error("result strobe without a matching transaction");

endmodule

### hw/rtl/nearest_neighbour_scaler_addr_unit.sv
// top level of the nearest-neighbour scaler address unit
// Takes one transaction per clock (busy is always low) and raises rsp_valid for its result;
// results leave in order and the receiver cannot stall them. Each transaction passes, in
// each axis, an offset stage, a multiply stage, twelve restoring-division stages giving one
// quotient bit each and a clamp stage, then two stages that form the linear address.
// Registers must be written through the csr port only while no transaction is in flight;
// the user is bound by this, and the block itself does not enforce it.
module nearest_neighbour_scaler_addr_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  nnsa_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   output nnsa_pkg::rsp_type                 rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [nnsa_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [nnsa_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [nnsa_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import nnsa_pkg::*;

   csr_type           cfg;
   axis_cfg_type      cfg_x;
   axis_cfg_type      cfg_y;
   logic              accept;
   logic              col_valid;
   logic              row_valid;
   logic [QUO_W-1:0]  col;
   logic [QUO_W-1:0]  row;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   nnsa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   always_comb begin
      cfg_x.sampling_mode = cfg.sampling_mode;
      cfg_x.size          = eff_size(cfg.src_width);
      cfg_x.origin        = cfg.origin_horizontal;
      cfg_x.extent        = cfg.extent_horizontal;
      cfg_y.sampling_mode = cfg.sampling_mode;
      cfg_y.size          = eff_size(cfg.src_height);
      cfg_y.origin        = cfg.origin_vertical;
      cfg_y.extent        = cfg.extent_vertical;
   end

   nnsa_axis u_axis_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .pos       (req_data.dest_col),
      .cfg       (cfg_x),
      .out_valid (col_valid),
      .index     (col)
   );

   nnsa_axis u_axis_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .pos       (req_data.dest_row),
      .cfg       (cfg_y),
      .out_valid (row_valid),
      .index     (row)
   );

   nnsa_addr u_addr (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (col_valid),
      .col       (col),
      .row       (row),
      .pitch     (cfg_x.size),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   axes_in_step: assert property (@(posedge clock) disable iff (reset)
      col_valid == row_valid)
      else $error("axis pipelines out of step");

endmodule
